// File: rtl/ps2_mouse_packet_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker assertion macros
// Shared concurrent assertion wrappers, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define PS2MPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ps2mpt: same-cycle assertion failed");

// next-cycle implication
`define PS2MPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ps2mpt: next-cycle assertion failed");

`endif

// File: rtl/ps2mpt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared types and constants for the packet tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mpt_pkg;

    localparam int DELTA_W     = 10;
    localparam int SYNC_BIT    = 3;
    localparam int X_SIGN_BIT  = 4;
    localparam int Y_SIGN_BIT  = 5;
    localparam int LEFT_BIT    = 0;
    localparam int RIGHT_BIT   = 1;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    typedef enum logic [2:0] {
        PHASE_FLAG = 3'b001,
        PHASE_DX   = 3'b010,
        PHASE_DY   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       from_aux;
    } in_item_t;

    typedef struct packed {
        logic left;
        logic right;
    } buttons_t;

endpackage

`default_nettype wire

// File: rtl/ps2mpt_clamp.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker coordinate clamp
// Adds a signed delta to a position and limits it to 0 .. size-1.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mpt_clamp
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic [COORD_BITS-1:0]    pos,
    input  wire logic signed [DELTA_W-1:0] delta,
    input  wire logic [COORD_BITS-1:0]    size,
    output logic      [COORD_BITS-1:0]    result
);

    localparam int SUM_W = COORD_BITS + 2;

    logic [COORD_BITS-1:0]   size_eff;
    logic [COORD_BITS-1:0]   max_coord;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] limit;

    always_comb begin
        size_eff  = (size == '0) ? COORD_BITS'(1) : size;
        max_coord = size_eff - COORD_BITS'(1);
        sum       = $signed({2'b00, pos}) + SUM_W'(delta);
        limit     = $signed({2'b00, size_eff});
        if (sum < 0) begin
            result = '0;
        end else if (sum >= limit) begin
            result = max_coord;
        end else begin
            result = sum[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ps2mpt_decoder.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker decoder
// Assembles three-byte packets and keeps the clamped cursor position.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_packet_tracker_unit_macros.svh"

module ps2mpt_decoder
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_valid,
    input  wire in_item_t              item,
    input  wire logic [COORD_BITS-1:0] screen_width,
    input  wire logic [COORD_BITS-1:0] screen_height,
    output logic                       pkt_done,
    output logic [COORD_BITS-1:0]      new_x,
    output logic [COORD_BITS-1:0]      new_y,
    output buttons_t                   buttons
);

    localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(384);

    phase_t                  phase_reg, phase_next;
    logic [7:0]              flag_reg, flag_next;
    logic [7:0]              dx_reg, dx_next;
    logic [COORD_BITS-1:0]   pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]   pos_y_reg, pos_y_next;
    logic                    take;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;

    assign take = item_valid && item.from_aux;

    always_comb begin
        delta_x = DELTA_W'($signed({flag_reg[X_SIGN_BIT], dx_reg}));
        delta_y = -DELTA_W'($signed({flag_reg[Y_SIGN_BIT], item.data_byte}));
    end

    ps2mpt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .pos    (pos_x_reg),
        .delta  (delta_x),
        .size   (screen_width),
        .result (new_x)
    );

    ps2mpt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .pos    (pos_y_reg),
        .delta  (delta_y),
        .size   (screen_height),
        .result (new_y)
    );

    always_comb begin
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        dx_next       = dx_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pkt_done      = 1'b0;
        buttons.left  = flag_reg[LEFT_BIT];
        buttons.right = flag_reg[RIGHT_BIT];
        if (take) begin
            unique case (phase_reg)
                PHASE_FLAG: begin
                    if (item.data_byte[SYNC_BIT]) begin
                        flag_next  = item.data_byte;
                        phase_next = PHASE_DX;
                    end
                end
                PHASE_DX: begin
                    dx_next    = item.data_byte;
                    phase_next = PHASE_DY;
                end
                PHASE_DY: begin
                    pos_x_next = new_x;
                    pos_y_next = new_y;
                    pkt_done   = 1'b1;
                    phase_next = PHASE_FLAG;
                end
                default: begin
                    phase_next = PHASE_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_FLAG;
            flag_reg  <= '0;
            dx_reg    <= '0;
            pos_x_reg <= POS_X_RESET;
            pos_y_reg <= POS_Y_RESET;
        end else begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            dx_reg    <= dx_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    `PS2MPT_ASSERT_NEXT(a_non_aux_no_change, aclk, aresetn, item_valid && !item.from_aux, $stable(phase_reg) && $stable(pos_x_reg) && $stable(pos_y_reg))
    `PS2MPT_ASSERT_NEXT(a_done_restarts, aclk, aresetn, pkt_done, phase_reg == PHASE_FLAG)
    `PS2MPT_ASSERT_NEXT(a_unsynced_dropped, aclk, aresetn, take && (phase_reg == PHASE_FLAG) && !item.data_byte[SYNC_BIT], phase_reg == PHASE_FLAG)

endmodule

`default_nettype wire

// File: rtl/ps2_mouse_packet_tracker_unit.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Bytes from the PS/2 mouse channel enter on s_*, one result per packet
// leaves on m_*, and the screen size registers are written on cfg_*.
// Bytes with s_from_aux low are dropped. Three bytes form a packet; a first
// byte without its sync bit is discarded to regain packet alignment.
// Each packet moves the cursor by its signed deltas (Y flipped to screen
// orientation), clamped to 0 .. size-1, and reports both buttons.
// A packet's last byte passes the input register and the decode logic into
// the result register, which raises m_valid. Throughput: one byte per cycle
// barring an m_* stall; set by the single input and single result register.
// s_ready stays high while the result register is free or being taken; a
// receiver stall holds the result and stops the input register only once
// it is also full. cfg_ready is always high; write only while idle.
// Reset: cursor at 512,384, screen 1024 by 768, packet alignment at the
// first byte, no transaction pending on either channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_packet_tracker_unit_macros.svh"

module ps2_mouse_packet_tracker_unit
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_data_byte,
    input  wire logic                  s_from_aux,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COORD_BITS-1:0]      m_cursor_x,
    output logic [COORD_BITS-1:0]      m_cursor_y,
    output logic                       m_left_pressed,
    output logic                       m_right_pressed,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data
);

    localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(1024);
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(768);

    logic                  in_valid_reg;
    in_item_t              in_item_reg;
    logic                  advance;
    logic                  pkt_done;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;
    buttons_t              buttons;
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;
    logic                  m_valid_reg;
    logic [COORD_BITS-1:0] m_x_reg;
    logic [COORD_BITS-1:0] m_y_reg;
    buttons_t              m_btn_reg;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.data_byte <= s_data_byte;
            in_item_reg.from_aux  <= s_from_aux;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ps2mpt_decoder #(.COORD_BITS(COORD_BITS)) u_decoder (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (in_valid_reg && advance),
        .item          (in_item_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .pkt_done      (pkt_done),
        .new_x         (new_x),
        .new_y         (new_y),
        .buttons       (buttons)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= pkt_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && pkt_done) begin
            m_x_reg   <= new_x;
            m_y_reg   <= new_y;
            m_btn_reg <= buttons;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_x      = m_x_reg;
    assign m_cursor_y      = m_y_reg;
    assign m_left_pressed  = m_btn_reg.left;
    assign m_right_pressed = m_btn_reg.right;

    `PS2MPT_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg && $stable(m_x_reg) && $stable(m_y_reg))
    `PS2MPT_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg))

endmodule

`default_nettype wire
